[src/shtp_rotation_report_deframer_unit_assert.svh]
// Assertion macros shared by the checker of the rotation report deframer.
`ifndef SHTP_ROTATION_REPORT_DEFRAMER_UNIT_ASSERT_SVH
`define SHTP_ROTATION_REPORT_DEFRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SHTP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shtp deframer check failed");

// Next-cycle implication, checked outside reset.
`define SHTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shtp deframer check failed");

`endif

[src/shtp_rrd_pkg.sv]
// Types and constants of the rotation report deframer.
package shtp_rrd_pkg;

    localparam logic [15:0] HDR_BYTES     = 16'd4;
    localparam logic [15:0] CAPTURE_LEN   = 16'd9;
    localparam logic [3:0]  CAPTURE_BYTES = 4'd9;
    localparam int          CAPTURE_DEPTH = 9;

    localparam logic [7:0]  RESET_REPORT_CHANNEL = 8'd3;
    localparam logic [7:0]  RESET_REPORT_ID      = 8'h05;
    localparam logic [15:0] RESET_MIN_LENGTH     = 16'd21;

    localparam logic [1:0] REG_REPORT_CHANNEL = 2'd0;
    localparam logic [1:0] REG_REPORT_ID      = 2'd1;
    localparam logic [1:0] REG_MIN_LENGTH     = 2'd2;

    localparam int DATA_WIDTH = 88;

    typedef enum logic [1:0] {
        STATUS_QUAT    = 2'd0,
        STATUS_SKIP    = 2'd1,
        STATUS_BAD_LEN = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0]  report_channel;
        logic [7:0]  rotation_report_id;
        logic [15:0] min_report_length;
    } cfg_t;

endpackage

[src/shtp_rrd_cfg.sv]
// APB register file holding the deframer configuration.
module shtp_rrd_cfg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output shtp_rrd_pkg::cfg_t  cfg
);
    import shtp_rrd_pkg::*;

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.report_channel     <= RESET_REPORT_CHANNEL;
            cfg_reg.rotation_report_id <= RESET_REPORT_ID;
            cfg_reg.min_report_length  <= RESET_MIN_LENGTH;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_REPORT_CHANNEL: cfg_reg.report_channel     <= pwdata[7:0];
                REG_REPORT_ID:      cfg_reg.rotation_report_id <= pwdata[7:0];
                REG_MIN_LENGTH:     cfg_reg.min_report_length  <= pwdata[15:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_REPORT_CHANNEL: prdata = {24'd0, cfg_reg.report_channel};
            REG_REPORT_ID:      prdata = {24'd0, cfg_reg.rotation_report_id};
            REG_MIN_LENGTH:     prdata = {16'd0, cfg_reg.min_report_length};
            default:            prdata = 32'd0;
        endcase
    end

endmodule

[src/shtp_rrd_parser.sv]
// Per-byte packet parser with payload capture and a registered result word.
module shtp_rrd_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  shtp_rrd_pkg::cfg_t  cfg,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [87:0]         m_axis_tdata,
    output logic [1:0]          m_axis_tuser
);
    import shtp_rrd_pkg::*;

    logic [1:0]  hdr_pos_reg,    hdr_pos_next;
    logic        in_payload_reg, in_payload_next;
    logic [7:0]  len_low_reg,    len_low_next;
    logic [15:0] remaining_reg,  remaining_next;
    logic [15:0] pkt_len_reg,    pkt_len_next;
    logic [7:0]  pkt_chan_reg,   pkt_chan_next;
    logic [3:0]  pay_idx_reg,    pay_idx_next;
    logic [7:0]  cap_reg [CAPTURE_DEPTH];
    logic [7:0]  cap_next [CAPTURE_DEPTH];

    logic                  out_valid_reg;
    logic [DATA_WIDTH-1:0] out_data_reg;
    status_t               out_user_reg;

    logic                  accept;
    logic                  emit;
    status_t               res_status;
    logic [15:0]           res_len;
    logic [15:0]           res_w, res_x, res_y, res_z;
    logic                  report_ok;
    logic [15:0]           full_len;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign full_len      = {s_axis_tdata, len_low_reg};

    always_comb
    begin
        hdr_pos_next    = hdr_pos_reg;
        in_payload_next = in_payload_reg;
        len_low_next    = len_low_reg;
        remaining_next  = remaining_reg;
        pkt_len_next    = pkt_len_reg;
        pkt_chan_next   = pkt_chan_reg;
        pay_idx_next    = pay_idx_reg;
        cap_next        = cap_reg;
        emit            = 1'b0;
        res_status      = STATUS_SKIP;
        res_len         = 16'd0;
        res_w           = 16'd0;
        res_x           = 16'd0;
        res_y           = 16'd0;
        res_z           = 16'd0;
        report_ok       = 1'b0;

        if (in_payload_reg)
        begin
            if (pay_idx_reg < CAPTURE_BYTES)
            begin
                cap_next[pay_idx_reg] = s_axis_tdata;
                pay_idx_next          = pay_idx_reg + 4'd1;
            end
            remaining_next = remaining_reg - 16'd1;
            if (remaining_reg == 16'd1)
            begin
                in_payload_next = 1'b0;
                emit            = 1'b1;
                report_ok       = (pkt_chan_reg == cfg.report_channel)
                               && (pkt_len_reg >= cfg.min_report_length)
                               && (pkt_len_reg >= CAPTURE_LEN)
                               && (cap_next[0] == cfg.rotation_report_id);
                res_len         = pkt_len_reg;
                if (report_ok)
                begin
                    res_status = STATUS_QUAT;
                    res_w      = {cap_next[8], cap_next[7]};
                    res_x      = {cap_next[2], cap_next[1]};
                    res_y      = {cap_next[4], cap_next[3]};
                    res_z      = {cap_next[6], cap_next[5]};
                end
            end
        end
        else
        begin
            case (hdr_pos_reg)
                2'd0:
                begin
                    len_low_next = s_axis_tdata;
                    hdr_pos_next = 2'd1;
                end
                2'd1:
                begin
                    pkt_len_next = full_len;
                    hdr_pos_next = 2'd2;
                end
                2'd2:
                begin
                    pkt_chan_next = s_axis_tdata;
                    hdr_pos_next  = 2'd3;
                end
                default:
                begin
                    hdr_pos_next = 2'd0;
                    pay_idx_next = 4'd0;
                    emit         = 1'b0;
                    if (pkt_len_reg < HDR_BYTES)
                    begin
                        pkt_len_next = 16'd0;
                        emit         = 1'b1;
                        res_status   = STATUS_BAD_LEN;
                    end
                    else if (pkt_len_reg == HDR_BYTES)
                    begin
                        pkt_len_next = 16'd0;
                        emit         = 1'b1;
                    end
                    else
                    begin
                        pkt_len_next    = pkt_len_reg - HDR_BYTES;
                        remaining_next  = pkt_len_reg - HDR_BYTES;
                        in_payload_next = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_pos_reg    <= 2'd0;
            in_payload_reg <= 1'b0;
            len_low_reg    <= 8'd0;
            remaining_reg  <= 16'd0;
            pkt_len_reg    <= 16'd0;
            pkt_chan_reg   <= 8'd0;
            pay_idx_reg    <= 4'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                hdr_pos_reg    <= hdr_pos_next;
                in_payload_reg <= in_payload_next;
                len_low_reg    <= len_low_next;
                remaining_reg  <= remaining_next;
                pkt_len_reg    <= pkt_len_next;
                pkt_chan_reg   <= pkt_chan_next;
                pay_idx_reg    <= pay_idx_next;
            end
            if (accept && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cap_reg <= cap_next;
        end
        if (accept && emit)
        begin
            out_data_reg <= {res_z, res_y, res_x, res_w, res_len, pkt_chan_reg};
            out_user_reg <= res_status;
        end
    end

endmodule

[src/shtp_rotation_report_deframer_unit.sv]
// Top level of the rotation report deframer: configuration registers and packet parser.
// The block takes one byte word per clock on the slave stream and issues one result word per
// packet on the master stream, in the cycle after the byte that closes the packet (the sequence
// byte for an empty or bad-length packet, else the last payload byte). Each byte is parsed in
// a single step between the parser state and the output register, so a byte is taken every
// cycle as long as result words are taken when offered. While a result word waits in the
// output register and the master side holds tready low, the slave side holds tready low too.
// Result tdata holds, from bit 0 up: channel_id, payload_length,
// quat_w, quat_x, quat_y, quat_z; tuser holds status (0 report, 1 skipped, 2 bad length).
module shtp_rotation_report_deframer_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // channel_id, payload_length, quat_w, quat_x, quat_y, quat_z
    output logic [1:0]  m_axis_tuser    // status
);
    import shtp_rrd_pkg::*;

    cfg_t cfg;

    shtp_rrd_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    shtp_rrd_parser u_parser
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

[src/shtp_rrd_checker.sv]
// Port-level checker of the rotation report deframer and its bind.
`include "shtp_rotation_report_deframer_unit_assert.svh"

module shtp_rrd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    import shtp_rrd_pkg::*;

    // A stalled result word keeps its valid and its contents.
    `SHTP_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // An empty output register never holds back the byte stream.
    `SHTP_ASSERT_SAME(a_ready_when_empty, clk, rst_n, !m_axis_tvalid, s_axis_tready)

    // A bad-length result carries no length and no quaternion.
    `SHTP_ASSERT_SAME(a_bad_len_zero, clk, rst_n, m_axis_tvalid && (m_axis_tuser == STATUS_BAD_LEN), m_axis_tdata[87:8] == 80'd0)

    // A skipped or bad-length result carries no quaternion, and the status code is always defined.
    `SHTP_ASSERT_SAME(a_skip_zero, clk, rst_n, m_axis_tvalid && (m_axis_tuser != STATUS_QUAT), (m_axis_tdata[87:24] == 64'd0) && (m_axis_tuser != 2'd3))

endmodule

bind shtp_rotation_report_deframer_unit shtp_rrd_checker u_shtp_rrd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
